### design/display_command_frame_parser_assert.svh
// Assertion macros for the frame parser checker.
`ifndef DISPLAY_COMMAND_FRAME_PARSER_ASSERT_SVH
`define DISPLAY_COMMAND_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define DCFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dcfp check failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define DCFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dcfp check failed");

`endif

### design/dcfp_pkg.sv
`default_nettype none

package dcfp_pkg;

  localparam int unsigned CntW = 9;

  localparam logic [CntW-1:0] CNT_MAX       = '1;
  localparam logic [CntW-1:0] MIN_FRAME_LEN = 9'd4;

  // Frame characters
  localparam logic [7:0] CH_OPEN  = 8'h7B;  // '{'
  localparam logic [7:0] CH_CLOSE = 8'h7D;  // '}'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_FIVE  = 8'h35;  // '5'
  localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'
  localparam logic [7:0] CH_EIGHT = 8'h38;  // '8'

  // Text position for commands that carry text
  localparam logic [2:0] TOFF_LINE   = 3'd5;
  localparam logic [2:0] TOFF_SCREEN = 3'd6;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FRAME   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_PARAM   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_FILL   = 3'd1,
    CMD_VER    = 3'd2,
    CMD_LINE   = 3'd3,
    CMD_SCREEN = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_BRIGHT = 3'd6,
    CMD_PERIPH = 3'd7
  } cmd_e;

  // Frame state after the current byte has been folded in
  typedef struct packed {
    logic [CntW-1:0] frame_len;
    logic            open_ok;
    logic [7:0]      cmd_byte;
    logic [7:0]      decl_len;
    logic [7:0]      param0;
    logic [7:0]      param1;
    logic [7:0]      param2;
  } frame_t;

  typedef struct packed {
    status_e    status;
    cmd_e       command;
    logic [7:0] param_length;
    logic [7:0] color;
    logic [7:0] row;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] brightness_level;
    logic [7:0] lamp_control;
    logic [2:0] text_offset;
    logic [7:0] text_length;
  } result_t;

endpackage

`default_nettype wire

### design/dcfp_capture.sv
`default_nettype none

// Per-frame capture of count, opening check, command, length and first parameters.
module dcfp_capture (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           end_i,
  output dcfp_pkg::frame_t    frame_o
);

  logic [dcfp_pkg::CntW-1:0] count_q, count_d;
  logic                      open_q, open_d;
  logic [7:0]                cmd_q, cmd_d;
  logic [7:0]                dlen_q, dlen_d;
  logic [7:0]                p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;

  // Fold the current byte into the frame state
  always_comb begin
    open_d = open_q;
    cmd_d  = cmd_q;
    dlen_d = dlen_q;
    p0_d   = p0_q;
    p1_d   = p1_q;
    p2_d   = p2_q;
    case (count_q)
      9'd0:    open_d = (byte_i == dcfp_pkg::CH_OPEN);
      9'd1:    cmd_d  = byte_i;
      9'd2:    dlen_d = byte_i;
      9'd3:    p0_d   = byte_i;
      9'd4:    p1_d   = byte_i;
      9'd5:    p2_d   = byte_i;
      default: ;
    endcase
    // saturate the count
    count_d = (count_q == dcfp_pkg::CNT_MAX) ? count_q : count_q + 9'd1;
  end

  assign frame_o = '{
    frame_len: count_d,
    open_ok:   open_d,
    cmd_byte:  cmd_d,
    decl_len:  dlen_d,
    param0:    p0_d,
    param1:    p1_d,
    param2:    p2_d
  };

  // Advance on every beat; drop back to empty after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      open_q  <= 1'b0;
      cmd_q   <= '0;
      dlen_q  <= '0;
      p0_q    <= '0;
      p1_q    <= '0;
      p2_q    <= '0;
    end else if (step_i) begin
      if (end_i) begin
        count_q <= '0;
        open_q  <= 1'b0;
        cmd_q   <= '0;
        dlen_q  <= '0;
        p0_q    <= '0;
        p1_q    <= '0;
        p2_q    <= '0;
      end else begin
        count_q <= count_d;
        open_q  <= open_d;
        cmd_q   <= cmd_d;
        dlen_q  <= dlen_d;
        p0_q    <= p0_d;
        p1_q    <= p1_d;
        p2_q    <= p2_d;
      end
    end
  end

endmodule

`default_nettype wire

### design/dcfp_verdict.sv
`default_nettype none

// Frame verdict: frame check, command decode, length overrun check, then per-command parameter check.
module dcfp_verdict (
  input  wire dcfp_pkg::frame_t frame_i,
  input  wire logic [7:0]       last_byte_i,
  output dcfp_pkg::result_t     result_o
);

  dcfp_pkg::cmd_e          cmd;
  logic [7:0]              dl;
  logic [7:0]              col;
  logic [7:0]              rw;
  logic [7:0]              lvl;
  logic [dcfp_pkg::CntW-1:0] room;
  logic                    frame_bad;

  // Decode the command character
  always_comb begin
    cmd = dcfp_pkg::CMD_NONE;
    if (frame_i.cmd_byte inside {[dcfp_pkg::CH_ONE:dcfp_pkg::CH_FIVE]}) begin
      cmd = dcfp_pkg::cmd_e'(frame_i.cmd_byte[2:0]);
    end else if (frame_i.cmd_byte == dcfp_pkg::CH_SEVEN) begin
      cmd = dcfp_pkg::CMD_BRIGHT;
    end else if (frame_i.cmd_byte == dcfp_pkg::CH_EIGHT) begin
      cmd = dcfp_pkg::CMD_PERIPH;
    end
  end

  assign dl        = frame_i.decl_len;
  assign col       = frame_i.param0 - dcfp_pkg::CH_ZERO;
  assign rw        = frame_i.param1 - dcfp_pkg::CH_ONE;
  assign lvl       = frame_i.param0 - dcfp_pkg::CH_ZERO;
  assign room      = frame_i.frame_len - dcfp_pkg::MIN_FRAME_LEN;
  assign frame_bad = (frame_i.frame_len < dcfp_pkg::MIN_FRAME_LEN) || !frame_i.open_ok ||
                     (last_byte_i != dcfp_pkg::CH_CLOSE);

  // Checks in order: frame, command, length overrun, parameters
  always_comb begin
    result_o        = '0;
    result_o.status = dcfp_pkg::ST_OK;
    if (frame_bad) begin
      result_o.status = dcfp_pkg::ST_FRAME;
    end else if (cmd == dcfp_pkg::CMD_NONE) begin
      result_o.status = dcfp_pkg::ST_UNKNOWN;
    end else if ({1'b0, dl} > room) begin
      result_o.status  = dcfp_pkg::ST_FRAME;
      result_o.command = cmd;
    end else begin
      result_o.command      = cmd;
      result_o.param_length = dl;
      case (cmd)
        dcfp_pkg::CMD_FILL: begin
          if (dl != 8'd1 || frame_i.param0 < 8'd1 || frame_i.param0 > 8'd3) begin
            result_o.status = dcfp_pkg::ST_PARAM;
          end else begin
            result_o.color = frame_i.param0 - 8'd1;
          end
        end
        dcfp_pkg::CMD_VER: begin
          if (dl != 8'd1) result_o.status = dcfp_pkg::ST_PARAM;
        end
        dcfp_pkg::CMD_LINE: begin
          if (dl < 8'd2) begin
            result_o.status = dcfp_pkg::ST_PARAM;
          end else begin
            result_o.color       = col;
            result_o.row         = rw;
            result_o.text_offset = dcfp_pkg::TOFF_LINE;
            result_o.text_length = dl - 8'd2;
            if (col > 8'd2 || rw > 8'd4) result_o.status = dcfp_pkg::ST_PARAM;
          end
        end
        dcfp_pkg::CMD_SCREEN: begin
          if (dl < 8'd3) begin
            result_o.status = dcfp_pkg::ST_PARAM;
          end else begin
            result_o.color       = col;
            result_o.pos_x       = frame_i.param1;
            result_o.pos_y       = frame_i.param2;
            result_o.text_offset = dcfp_pkg::TOFF_SCREEN;
            result_o.text_length = dl - 8'd3;
            if (col > 8'd2) result_o.status = dcfp_pkg::ST_PARAM;
          end
        end
        dcfp_pkg::CMD_CLEAR: begin
          if (dl != 8'd0) result_o.status = dcfp_pkg::ST_PARAM;
        end
        dcfp_pkg::CMD_BRIGHT: begin
          if (dl != 8'd1) begin
            result_o.status = dcfp_pkg::ST_PARAM;
          end else begin
            result_o.brightness_level = lvl;
            if (lvl > 8'd5) result_o.status = dcfp_pkg::ST_PARAM;
          end
        end
        dcfp_pkg::CMD_PERIPH: begin
          if (dl != 8'd1) begin
            result_o.status = dcfp_pkg::ST_PARAM;
          end else begin
            result_o.lamp_control = frame_i.param0;
          end
        end
        default: result_o.status = dcfp_pkg::ST_UNKNOWN;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/display_command_frame_parser.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   frame_byte_i, frame_end_i
// out       output     out_valid_o / out_ready_i status_o .. text_length_o (one per frame)
//
// A final byte passes through the input register, then the result register (once that
// is free), before its verdict shows on out_valid_o.
// One byte per cycle is accepted while no final byte waits on a stalled output; the
// frame state update plus the verdict logic between the two registers sets that figure.
// A stalled output holds only the final byte of a frame; other bytes keep flowing.
// rst_ni clears the frame state and both valid flags asynchronously.
`default_nettype none

module display_command_frame_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] frame_byte_i,
  input  wire logic       frame_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      status_o,
  output logic [2:0]      command_o,
  output logic [7:0]      param_length_o,
  output logic [7:0]      color_o,
  output logic [7:0]      row_o,
  output logic [7:0]      pos_x_o,
  output logic [7:0]      pos_y_o,
  output logic [7:0]      brightness_level_o,
  output logic [7:0]      lamp_control_o,
  output logic [2:0]      text_offset_o,
  output logic [7:0]      text_length_o
);

  logic              in_vld_q, in_vld_d;
  logic [7:0]        in_byte_q;
  logic              in_end_q;
  logic              out_vld_q, out_vld_d;
  dcfp_pkg::result_t res_q, res_d;
  dcfp_pkg::frame_t  frame;
  logic              out_free;
  logic              s1_adv;
  logic              res_load;

  // Handshake: non-final beats always drain, final beats wait for a free result slot
  assign out_free   = !out_vld_q || out_ready_i;
  assign s1_adv     = in_vld_q && (!in_end_q || out_free);
  assign res_load   = in_vld_q && in_end_q && out_free;
  assign in_ready_o = !in_vld_q || s1_adv;

  dcfp_capture u_capture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .byte_i  (in_byte_q),
    .end_i   (in_end_q),
    .frame_o (frame)
  );

  dcfp_verdict u_verdict (
    .frame_i     (frame),
    .last_byte_i (in_byte_q),
    .result_o    (res_d)
  );

  // Input register valid
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (s1_adv) begin
      in_vld_d = 1'b0;
    end
  end

  // Result register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (res_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= frame_byte_i;
      in_end_q  <= frame_end_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign status_o           = res_q.status;
  assign command_o          = res_q.command;
  assign param_length_o     = res_q.param_length;
  assign color_o            = res_q.color;
  assign row_o              = res_q.row;
  assign pos_x_o            = res_q.pos_x;
  assign pos_y_o            = res_q.pos_y;
  assign brightness_level_o = res_q.brightness_level;
  assign lamp_control_o     = res_q.lamp_control;
  assign text_offset_o      = res_q.text_offset;
  assign text_length_o      = res_q.text_length;

endmodule

`default_nettype wire

### design/dcfp_checker.sv
`default_nettype none
`include "display_command_frame_parser_assert.svh"

// Port-level checks on the frame parser verdicts.
module dcfp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] status_o,
  input wire logic [2:0] command_o,
  input wire logic [7:0] param_length_o,
  input wire logic [2:0] text_offset_o
);

  logic out_stall;
  logic text_cmd;
  logic unknown_seen;
  logic unknown_clean;
  logic text_seen;
  logic text_ok;
  logic none_seen;
  logic none_ok;

  assign out_stall     = out_valid_o && !out_ready_i;
  assign text_cmd      = (command_o == dcfp_pkg::CMD_LINE) ||
                         (command_o == dcfp_pkg::CMD_SCREEN);
  assign unknown_seen  = out_valid_o && (status_o == dcfp_pkg::ST_UNKNOWN);
  assign unknown_clean = (command_o == dcfp_pkg::CMD_NONE) && (param_length_o == 8'd0) &&
                         (text_offset_o == 3'd0);
  assign text_seen     = out_valid_o && (text_offset_o != 3'd0);
  assign text_ok       = text_cmd && (status_o != dcfp_pkg::ST_FRAME);
  assign none_seen     = out_valid_o && (command_o == dcfp_pkg::CMD_NONE);
  assign none_ok       = (status_o == dcfp_pkg::ST_FRAME) || (status_o == dcfp_pkg::ST_UNKNOWN);

  // A stalled verdict holds its status and command
  `DCFP_ASSERT_NEXT(a_hold_verdict, out_stall, out_valid_o && $stable({status_o, command_o}))

  // Unknown command reports nothing else
  `DCFP_ASSERT_NOW(a_unknown_clean, unknown_seen, unknown_clean)

  // Only line and screen commands carry text
  `DCFP_ASSERT_NOW(a_text_cmd, text_seen, text_ok)

  // No decoded command means a frame or command failure
  `DCFP_ASSERT_NOW(a_none_fails, none_seen, none_ok)

endmodule

bind display_command_frame_parser dcfp_checker u_dcfp_checker (.*);

`default_nettype wire

### sim/display_command_frame_parser_tb.sv
`timescale 1ns / 100ps

module display_command_frame_parser_tb;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned phase;
    bit          drain;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  frame_byte = '0;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [2:0]  command;
  logic [7:0]  param_length;
  logic [7:0]  color;
  logic [7:0]  row;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [7:0]  brightness_level;
  logic [7:0]  lamp_control;
  logic [2:0]  text_offset;
  logic [7:0]  text_length;

  // Pending input beats, the frame under assembly and the expected verdicts
  beat_t              beat_q[$];
  logic [7:0]         frm[$];
  dcfp_pkg::result_t  verdict_q[$];
  beat_t              next_beat;
  int unsigned        cur_phase = 0;
  int unsigned        mismatches = 0;

  // Idle percentages per phase: sender, then receiver
  int unsigned send_idle_pct [3] = '{13, 72, 0};
  int unsigned recv_idle_pct [3] = '{72, 13, 0};

  // Predictor copy of the frame state
  logic [8:0]  frame_cnt = '0;
  logic        open_seen = 1'b0;
  logic [7:0]  cmd_char = '0;
  logic [7:0]  len_field = '0;
  logic [7:0]  prm [3] = '{8'd0, 8'd0, 8'd0};

  display_command_frame_parser i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .frame_byte_i       (frame_byte),
    .frame_end_i        (frame_end),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .status_o           (status),
    .command_o          (command),
    .param_length_o     (param_length),
    .color_o            (color),
    .row_o              (row),
    .pos_x_o            (pos_x),
    .pos_y_o            (pos_y),
    .brightness_level_o (brightness_level),
    .lamp_control_o     (lamp_control),
    .text_offset_o      (text_offset),
    .text_length_o      (text_length)
  );

  always #6 clk = ~clk;

  // Map a command character to its code
  function automatic dcfp_pkg::cmd_e decode_cmd(input logic [7:0] c);
    if (c >= dcfp_pkg::CH_ONE && c <= dcfp_pkg::CH_FIVE) begin
      return dcfp_pkg::cmd_e'(3'(c - dcfp_pkg::CH_ZERO));
    end else if (c == dcfp_pkg::CH_SEVEN) begin
      return dcfp_pkg::CMD_BRIGHT;
    end else if (c == dcfp_pkg::CH_EIGHT) begin
      return dcfp_pkg::CMD_PERIPH;
    end
    return dcfp_pkg::CMD_NONE;
  endfunction

  // Work out the verdict for a frame whose final byte is b
  function automatic dcfp_pkg::result_t frame_verdict(input logic [7:0] b);
    dcfp_pkg::result_t v;
    dcfp_pkg::cmd_e    c;
    v = '0;
    c = decode_cmd(cmd_char);
    if (frame_cnt < dcfp_pkg::MIN_FRAME_LEN || !open_seen || b != dcfp_pkg::CH_CLOSE) begin
      v.status = dcfp_pkg::ST_FRAME;
    end else if (c == dcfp_pkg::CMD_NONE) begin
      v.status = dcfp_pkg::ST_UNKNOWN;
    end else if (int'(frame_cnt) - 4 < int'(len_field)) begin
      v.status  = dcfp_pkg::ST_FRAME;
      v.command = c;
    end else begin
      v.status       = dcfp_pkg::ST_OK;
      v.command      = c;
      v.param_length = len_field;
      case (c)
        dcfp_pkg::CMD_FILL: begin
          if (len_field != 8'd1 || prm[0] < 8'd1 || prm[0] > 8'd3) v.status = dcfp_pkg::ST_PARAM;
          else v.color = prm[0] - 8'd1;
        end
        dcfp_pkg::CMD_VER: begin
          if (len_field != 8'd1) v.status = dcfp_pkg::ST_PARAM;
        end
        dcfp_pkg::CMD_LINE: begin
          if (len_field < 8'd2) begin
            v.status = dcfp_pkg::ST_PARAM;
          end else begin
            v.color       = prm[0] - dcfp_pkg::CH_ZERO;
            v.row         = prm[1] - dcfp_pkg::CH_ONE;
            v.text_offset = dcfp_pkg::TOFF_LINE;
            v.text_length = len_field - 8'd2;
            if (v.color > 8'd2 || v.row > 8'd4) v.status = dcfp_pkg::ST_PARAM;
          end
        end
        dcfp_pkg::CMD_SCREEN: begin
          if (len_field < 8'd3) begin
            v.status = dcfp_pkg::ST_PARAM;
          end else begin
            v.color       = prm[0] - dcfp_pkg::CH_ZERO;
            v.pos_x       = prm[1];
            v.pos_y       = prm[2];
            v.text_offset = dcfp_pkg::TOFF_SCREEN;
            v.text_length = len_field - 8'd3;
            if (v.color > 8'd2) v.status = dcfp_pkg::ST_PARAM;
          end
        end
        dcfp_pkg::CMD_CLEAR: begin
          if (len_field != 8'd0) v.status = dcfp_pkg::ST_PARAM;
        end
        dcfp_pkg::CMD_BRIGHT: begin
          if (len_field != 8'd1) begin
            v.status = dcfp_pkg::ST_PARAM;
          end else begin
            v.brightness_level = prm[0] - dcfp_pkg::CH_ZERO;
            if (v.brightness_level > 8'd5) v.status = dcfp_pkg::ST_PARAM;
          end
        end
        default: begin
          if (len_field != 8'd1) v.status = dcfp_pkg::ST_PARAM;
          else v.lamp_control = prm[0];
        end
      endcase
    end
    return v;
  endfunction

  // Fold one accepted beat into the frame state; queue a verdict on the final byte
  task automatic fold_byte(input logic [7:0] b, input logic last);
    case (frame_cnt)
      9'd0: open_seen = (b == dcfp_pkg::CH_OPEN);
      9'd1: cmd_char = b;
      9'd2: len_field = b;
      9'd3, 9'd4, 9'd5: prm[frame_cnt - 9'd3] = b;
      default: ;
    endcase
    if (frame_cnt != dcfp_pkg::CNT_MAX) frame_cnt = frame_cnt + 9'd1;
    if (last) begin
      verdict_q.push_back(frame_verdict(b));
      frame_cnt = '0;
      open_seen = 1'b0;
      cmd_char  = '0;
      len_field = '0;
      prm       = '{8'd0, 8'd0, 8'd0};
    end
  endtask

  // Turn the frame under assembly into beats, final flag on the last one
  task automatic push_frame(input int unsigned ph, input bit drain);
    beat_t bt;
    for (int k = 0; k < frm.size(); k++) begin
      bt.data  = frm[k];
      bt.last  = (k == frm.size() - 1);
      bt.phase = ph;
      bt.drain = drain && (k == 0);
      beat_q.push_back(bt);
    end
    frm.delete();
  endtask

  function automatic logic [7:0] rand_param();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return dcfp_pkg::CH_ZERO + 8'($urandom_range(9));
    if (r < 70) return 8'($urandom_range(4));
    return 8'($urandom_range(255));
  endfunction

  // Build one random frame: mostly well formed, the rest noise or broken
  task automatic random_frame(input int unsigned ph, input bit drain);
    int unsigned n;
    int unsigned pick;
    logic [7:0]  cmd;
    logic [7:0]  dl;
    frm.delete();
    if ($urandom_range(99) < 75) begin
      case ($urandom_range(7))
        5: cmd = dcfp_pkg::CH_SEVEN;
        6: cmd = dcfp_pkg::CH_EIGHT;
        7: cmd = 8'($urandom_range(255));
        default: cmd = dcfp_pkg::CH_ZERO + 8'($urandom_range(1, 5));
      endcase
      pick = $urandom_range(99);
      if (pick < 75) begin
        case (cmd)
          dcfp_pkg::CH_FIVE:        dl = 8'd0;
          dcfp_pkg::CH_ZERO + 8'd3: dl = 8'($urandom_range(2, 6));
          dcfp_pkg::CH_ZERO + 8'd4: dl = 8'($urandom_range(3, 7));
          default:                  dl = 8'd1;
        endcase
      end else if (pick < 92) begin
        dl = 8'($urandom_range(8));
      end else begin
        dl = 8'($urandom_range(9, 255));
      end
      if (dl <= 8'd8 && $urandom_range(99) < 90) n = dl;
      else n = $urandom_range(9);
      frm.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : dcfp_pkg::CH_OPEN);
      frm.push_back(cmd);
      frm.push_back(dl);
      for (int k = 0; k < n; k++) frm.push_back(rand_param());
      frm.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : dcfp_pkg::CH_CLOSE);
    end else begin
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) frm.push_back(8'($urandom_range(255)));
      if ($urandom_range(2) == 0) frm[0] = dcfp_pkg::CH_OPEN;
      if ($urandom_range(2) == 0) frm[n - 1] = dcfp_pkg::CH_CLOSE;
    end
    push_frame(ph, drain);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Drive input beats; predict on each accepted beat
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      frame_byte <= '0;
      frame_end  <= 1'b0;
    end else begin
      if (in_valid && in_ready) fold_byte(frame_byte, frame_end);
      if (!in_valid || in_ready) begin
        if (beat_q.size() != 0 && !(beat_q[0].drain && verdict_q.size() != 0) &&
            $urandom_range(99) >= send_idle_pct[beat_q[0].phase]) begin
          next_beat = beat_q.pop_front();
          in_valid   <= 1'b1;
          frame_byte <= next_beat.data;
          frame_end  <= next_beat.last;
          cur_phase  <= next_beat.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Accept result beats and compare against the oldest expected verdict
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no frame pending");
          mismatches++;
        end else begin
          check_field("status", verdict_q[0].status, status);
          check_field("command", verdict_q[0].command, command);
          check_field("param_length", verdict_q[0].param_length, param_length);
          check_field("color", verdict_q[0].color, color);
          check_field("row", verdict_q[0].row, row);
          check_field("pos_x", verdict_q[0].pos_x, pos_x);
          check_field("pos_y", verdict_q[0].pos_y, pos_y);
          check_field("brightness_level", verdict_q[0].brightness_level,
                      brightness_level);
          check_field("lamp_control", verdict_q[0].lamp_control, lamp_control);
          check_field("text_offset", verdict_q[0].text_offset, text_offset);
          check_field("text_length", verdict_q[0].text_length, text_length);
          void'(verdict_q.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned base;
    int unsigned ph;
    int unsigned prev_ph;

    // Fill: good, zero parameter
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ONE, 8'd1, 8'd3, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ONE, 8'd1, 8'd0, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    // Version: good, wrong length
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ZERO + 8'd2, 8'd1, 8'hFF, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ZERO + 8'd2, 8'd0, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    // Line: good with text, bad row, too short
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ZERO + 8'd3, 8'd4, dcfp_pkg::CH_ZERO + 8'd2,
            dcfp_pkg::CH_FIVE, 8'h41, 8'h42, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ZERO + 8'd3, 8'd2, dcfp_pkg::CH_ZERO,
            dcfp_pkg::CH_ZERO + 8'd6, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ZERO + 8'd3, 8'd1, dcfp_pkg::CH_ZERO,
            dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    // Screen: good with raw extremes, bad color
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ZERO + 8'd4, 8'd5, dcfp_pkg::CH_ZERO, 8'h00,
            8'hFF, 8'h61, 8'h62, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ZERO + 8'd4, 8'd3, dcfp_pkg::CH_ZERO + 8'd3,
            8'd7, 8'd9, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    // Clear: good, extra length
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_FIVE, 8'd0, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_FIVE, 8'd1, 8'd0, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    // Brightness: automatic, top level, out of range
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_SEVEN, 8'd1, dcfp_pkg::CH_ZERO,
            dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_SEVEN, 8'd1, dcfp_pkg::CH_FIVE,
            dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_SEVEN, 8'd1, dcfp_pkg::CH_ZERO + 8'd6,
            dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    // Peripheral: good, wrong length
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_EIGHT, 8'd1, 8'h07, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_EIGHT, 8'd2, 8'h01, 8'h02, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    // Unknown commands
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ZERO + 8'd6, 8'd0, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, 8'h00, 8'd0, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    // Short frames, bad opening and closing bytes
    frm = '{dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_FIVE, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{8'h00, dcfp_pkg::CH_FIVE, 8'd0, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_FIVE, 8'd0, 8'hFF};
    push_frame(0, 0);
    // Declared length past the closing byte
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ONE, 8'd5, 8'd1, dcfp_pkg::CH_CLOSE};
    push_frame(0, 0);
    // Long line frame of 512 bytes: byte count saturates, length still fits
    frm = '{dcfp_pkg::CH_OPEN, dcfp_pkg::CH_ZERO + 8'd3, 8'd255, dcfp_pkg::CH_ZERO,
            dcfp_pkg::CH_ONE};
    for (int k = 0; k < 506; k++) frm.push_back(8'($urandom_range(255)));
    frm.push_back(dcfp_pkg::CH_CLOSE);
    push_frame(0, 1);

    // Random frames over three idle phases; drain at each phase change and now and then at random
    base = beat_q.size();
    prev_ph = 0;
    while (beat_q.size() - base < 90) begin
      ph = ((beat_q.size() - base) * 3) / 90;
      random_frame(ph, (ph != prev_ph) || ($urandom_range(39) == 0));
      prev_ph = ph;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all beats to go in and every verdict to come out
    while (beat_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### display_command_frame_parser.f
+incdir+design
design/dcfp_pkg.sv
design/dcfp_capture.sv
design/dcfp_verdict.sv
design/display_command_frame_parser.sv
design/dcfp_checker.sv
sim/display_command_frame_parser_tb.sv
